// ----- rtl/core/bsv_pkg.sv -----
// ----------------------------------------------------------------------------
// bsv_pkg
// shared types, codes and helpers for the b-spline value evaluator
// ----------------------------------------------------------------------------
package bsv_pkg;

  // default sizes, handed to the top level parameters
  localparam int MAX_ORDER_DEF     = 8;
  localparam int MAX_COEFS_DEF     = 64;
  localparam int FRACTION_BITS_DEF = 16;

  // fixed field widths
  localparam int KIND_W  = 2;
  localparam int IDX_W   = 7;
  localparam int VAL_W   = 32;
  localparam int STAT_W  = 3;
  localparam int CFG_W   = 7;
  localparam int CIDX_W  = 2;
  localparam int ORD_W   = 4;
  localparam int CNT_W   = 7;
  // difference of two values, and sum of two differences
  localparam int DIFF_W  = VAL_W + 1;
  localparam int DEN_W   = VAL_W + 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_KNOT = 2'd0,
    KIND_COEF = 2'd1,
    KIND_EVAL = 2'd2
  } kind_t;

  typedef enum logic [CIDX_W-1:0] {
    REG_ORDER = 2'd0,
    REG_COUNT = 2'd1,
    REG_DERIV = 2'd2
  } reg_idx_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK           = 3'd0,
    ST_BAD_ORDER    = 3'd1,
    ST_FEW_COEFS    = 3'd2,
    ST_KNOT_DEC     = 3'd3,
    ST_MULTIPLICITY = 3'd4,
    ST_X_NOT_INC    = 3'd5
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CHK_ORD,
    S_MONO_RD,
    S_MONO_CMP,
    S_MULT_A,
    S_MULT_B,
    S_MULT_C,
    S_CHK_PT,
    S_LOC_T0,
    S_LOC_TL,
    S_LOC_S,
    S_LOC_SC,
    S_LOC_EXP,
    S_LOC_EXPC,
    S_LOC_BIN,
    S_LOC_BINC,
    S_LOC_LAST,
    S_LOC_DEC,
    S_LOC_DECC,
    S_LOC_FLAG,
    S_DL_RD,
    S_DL_W,
    S_DR_W,
    S_AJ_RD,
    S_AJ_W,
    S_OUTER,
    S_ISSUE,
    S_DIV,
    S_MUL,
    S_WB,
    S_DONE
  } state_t;

  // table write strobes
  typedef struct packed {
    logic knot_we;
    logic coef_we;
  } tbl_ctl_t;

  localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
  localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [63:0] v);
    logic signed [VAL_W-1:0] r;
    if (v > SAT_MAX) begin
      r = SAT_MAX[VAL_W-1:0];
    end else if (v < SAT_MIN) begin
      r = SAT_MIN[VAL_W-1:0];
    end else begin
      r = v[VAL_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/bsv_divider.sv -----
// ----------------------------------------------------------------------------
// bsv_divider
// radix-2 restoring divider, fixed-point quotient num*2^F/den, truncating
// ----------------------------------------------------------------------------
module bsv_divider import bsv_pkg::*; #(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  input  logic signed [DEN_W-1:0]                num,
  input  logic signed [DEN_W-1:0]                den,
  output logic                                   done,
  output logic signed [DEN_W+FRACTION_BITS:0]    quo
);

  localparam int DVD_W = DEN_W + FRACTION_BITS;
  localparam int DC_W  = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] dvd_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic             neg_r;
  logic             zero_r;
  logic             busy_r;
  logic             done_r;
  logic [DC_W-1:0]  cnt_r;

  logic [DEN_W-1:0] num_mag;
  logic [DEN_W-1:0] den_mag;
  logic [DEN_W:0]   rem_sh;
  logic             ge;

  assign num_mag = num[DEN_W-1] ? DEN_W'(-num) : DEN_W'(num);
  assign den_mag = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
  assign rem_sh  = {rem_r, dvd_r[DVD_W-1]};
  assign ge      = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DC_W'(DVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DC_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r  <= {num_mag, {FRACTION_BITS{1'b0}}};
      rem_r  <= '0;
      den_r  <= den_mag;
      neg_r  <= num[DEN_W-1] ^ den[DEN_W-1];
      zero_r <= (den == '0);
    end else if (busy_r) begin
      rem_r <= ge ? DEN_W'(rem_sh - {1'b0, den_r}) : rem_sh[DEN_W-1:0];
      dvd_r <= {dvd_r[DVD_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = zero_r ? '0 : (neg_r ? -$signed({1'b0, dvd_r}) : $signed({1'b0, dvd_r}));

endmodule

// ----- rtl/core/bsv_tables.sv -----
// ----------------------------------------------------------------------------
// bsv_tables
// knot and coefficient memories, one write and one registered read port each
// ----------------------------------------------------------------------------
module bsv_tables import bsv_pkg::*; #(
  parameter int MAX_ORDER = MAX_ORDER_DEF,
  parameter int MAX_COEFS = MAX_COEFS_DEF,
  parameter int KA_W      = $clog2(MAX_COEFS + MAX_ORDER),
  parameter int CA_W      = $clog2(MAX_COEFS)
) (
  input  logic                    clk,
  input  tbl_ctl_t                ctl,
  input  logic [IDX_W-1:0]        wr_addr,
  input  logic signed [VAL_W-1:0] wr_data,
  input  logic [KA_W-1:0]         knot_raddr,
  input  logic [CA_W-1:0]         coef_raddr,
  output logic signed [VAL_W-1:0] knot_q,
  output logic signed [VAL_W-1:0] coef_q
);

  localparam int KNOT_DEPTH = MAX_COEFS + MAX_ORDER;
  localparam int XW = (KA_W > IDX_W) ? KA_W : IDX_W;

  logic signed [VAL_W-1:0] knot_mem [KNOT_DEPTH];
  logic signed [VAL_W-1:0] coef_mem [MAX_COEFS];

  logic [XW-1:0] wa_x;
  logic          knot_in_range;
  logic          coef_in_range;

  assign wa_x          = XW'(wr_addr);
  // loads beyond a table are dropped
  assign knot_in_range = int'(wr_addr) < KNOT_DEPTH;
  assign coef_in_range = int'(wr_addr) < MAX_COEFS;

  always_ff @(posedge clk) begin
    if (ctl.knot_we && knot_in_range) begin
      knot_mem[wa_x[KA_W-1:0]] <= wr_data;
    end
    knot_q <= knot_mem[knot_raddr];
  end

  always_ff @(posedge clk) begin
    if (ctl.coef_we && coef_in_range) begin
      coef_mem[wa_x[CA_W-1:0]] <= wr_data;
    end
    coef_q <= coef_mem[coef_raddr];
  end

endmodule

// ----- rtl/core/bspline_value_evaluator.sv -----
// ----------------------------------------------------------------------------
// bspline_value_evaluator
// b-spline value and derivative evaluation by de boor's recurrence, Qm.F
// ----------------------------------------------------------------------------
// Knot and coefficient words are written into two synchronous memories, each
// with one write and one read port, one word per cycle while the sequencer is
// idle, and never produce a result. An evaluate word is taken only when the
// sequencer is idle and runs alone: validation walks the knot memory, the
// interval search probes one knot at a time, each with a read and a compare
// state, starting from the interval kept from the last point (from zero on a
// first point), and the de boor phase then performs k(k-1)/2 fixed-point
// divisions on one shared bit-serial divider, each step issuing, dividing,
// multiplying and writing back. A bad order or count finishes at the first
// check, knot errors during validation, a falling point after validation and
// an out-of-range point after the search. The result word is held in an
// output register, so load words keep flowing while it waits to be taken.
// ----------------------------------------------------------------------------
module bspline_value_evaluator import bsv_pkg::*; #(
  parameter int MAX_ORDER     = MAX_ORDER_DEF,
  parameter int MAX_COEFS     = MAX_COEFS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // configuration
  input  logic                     cfg_we,
  input  logic [CIDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  // input words
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [KIND_W-1:0]        in_kind,
  input  logic [IDX_W-1:0]         in_entry_index,
  input  logic signed [VAL_W-1:0]  in_operand_value,
  input  logic                     in_first_point,
  // result words
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [VAL_W-1:0]  out_result_value,
  output logic [STAT_W-1:0]        out_status
);

  localparam int KNOT_DEPTH = MAX_COEFS + MAX_ORDER;
  localparam int KA_W  = $clog2(KNOT_DEPTH);
  localparam int CA_W  = $clog2(MAX_COEFS);
  localparam int POS_W = KA_W + 2;
  localparam int OI_W  = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int QW1   = DEN_W + FRACTION_BITS + 1;
  localparam int WW    = FRACTION_BITS + 2;
  localparam int PDW   = QW1 + OI_W + 1;
  localparam int PRW   = DIFF_W + WW;
  localparam logic signed [PRW-1:0] RND = PRW'((64'd1 << FRACTION_BITS) - 1);

  // control state
  state_t               state_r, state_nxt;
  logic [ORD_W-1:0]     k_r;
  logic [CNT_W-1:0]     n_r;
  logic [ORD_W-1:0]     jd_r;
  logic [KA_W-1:0]      search_start_r, search_start_nxt;
  logic signed [VAL_W-1:0] prev_pt_r, prev_pt_nxt;
  logic                 out_valid_r, out_valid_nxt;

  // working registers of one evaluation
  logic signed [VAL_W-1:0] x_r, x_nxt;
  logic                 first_r, first_nxt;
  status_t              status_r, status_nxt;
  logic signed [VAL_W-1:0] res_r, res_nxt;
  logic signed [VAL_W-1:0] out_res_r, out_res_nxt;
  status_t              out_stat_r, out_stat_nxt;
  logic [POS_W-1:0]     m_r, m_nxt;
  logic signed [VAL_W-1:0] tmp_r, tmp_nxt;
  logic signed [VAL_W-1:0] t0_r, t0_nxt;
  logic signed [VAL_W-1:0] tl_r, tl_nxt;
  logic [POS_W-1:0]     ilo_r, ilo_nxt;
  logic [POS_W-1:0]     ihi_r, ihi_nxt;
  logic [POS_W-1:0]     mid_r, mid_nxt;
  logic [OI_W-1:0]      j_r, j_nxt;
  logic [OI_W-1:0]      lv_r, lv_nxt;
  logic [OI_W-1:0]      p_r, p_nxt;
  logic                 cval_r, cval_nxt;
  logic signed [VAL_W-1:0] prev_r, prev_nxt;
  logic signed [VAL_W-1:0] cur_r, cur_nxt;
  logic signed [DIFF_W-1:0] diffab_r, diffab_nxt;
  logic                 diffph_r, diffph_nxt;
  logic signed [PDW-1:0] prodd_r, prodd_nxt;
  logic signed [PRW-1:0] prodr_r, prodr_nxt;

  // de boor workspace: coefficients and left/right distances
  logic signed [VAL_W-1:0]  aj_r [MAX_ORDER];
  logic signed [DIFF_W-1:0] dl_r [MAX_ORDER];
  logic signed [DIFF_W-1:0] dr_r [MAX_ORDER];
  logic                     aj_we, dl_we, dr_we;
  logic [OI_W-1:0]          aj_wa, dx_wa;
  logic signed [VAL_W-1:0]  aj_wd;
  logic signed [DIFF_W-1:0] dl_wd, dr_wd;

  // memory ports
  tbl_ctl_t                tbl_ctl;
  logic [KA_W-1:0]         knot_raddr;
  logic [CA_W-1:0]         coef_raddr;
  logic signed [VAL_W-1:0] knot_q;
  logic signed [VAL_W-1:0] coef_q;

  // divider
  logic                    div_start;
  logic signed [DEN_W-1:0] div_num;
  logic signed [DEN_W-1:0] div_den;
  logic                    div_done;
  logic signed [QW1-1:0]   div_quo;

  // helpers
  logic                    in_acc;
  logic [POS_W-1:0]        lxt, lxt_m1, lxt_m2;
  logic [POS_W-1:0]        ss_eff;
  logic [POS_W-1:0]        li, ri, ri_raw, ihi_exp;
  logic signed [POS_W:0]   c_s;
  logic [OI_W-1:0]         p_inc, dl_idx;
  logic signed [DIFF_W-1:0] dlv, drv;
  logic signed [VAL_W-1:0] hi_v;
  logic signed [PRW-1:0]   rnd_v;
  logic signed [VAL_W-1:0] wb_v;
  logic signed [WW-1:0]    w_v;

  assign in_acc = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);

  assign lxt    = POS_W'(n_r) + POS_W'(k_r);
  assign lxt_m1 = lxt - 1'b1;
  assign lxt_m2 = lxt - POS_W'(2);
  assign ss_eff = first_r ? '0 : POS_W'(search_start_r);

  // clamped knot positions for the distance fill
  assign li     = (ilo_r >= POS_W'(j_r)) ? (ilo_r - POS_W'(j_r)) : '0;
  assign ri_raw = ilo_r + POS_W'(j_r) + 1'b1;
  assign ri     = (ri_raw > lxt_m1) ? lxt_m1 : ri_raw;
  // coefficient index i-k+1+j, may fall below zero
  assign c_s    = $signed({1'b0, ilo_r}) + $signed((POS_W+1)'(j_r))
                - $signed((POS_W+1)'(k_r)) + $signed((POS_W+1)'(1));
  // doubling step of the upward search, clipped to the last knot
  assign ihi_exp = ((ihi_r << 1) - ilo_r > lxt_m1) ? lxt_m1 : ((ihi_r << 1) - ilo_r);

  assign p_inc  = p_r + 1'b1;
  assign dl_idx = lv_r - 1'b1 - p_r;
  assign dlv    = dl_r[dl_idx];
  assign drv    = dr_r[p_r];
  assign hi_v   = aj_r[p_inc];
  assign w_v    = div_quo[WW-1:0];

  // rounding of the weighted step toward zero
  assign rnd_v  = prodr_r[PRW-1] ? (prodr_r + RND) : prodr_r;
  assign wb_v   = diffph_r ? sat32(64'(prodd_r))
                           : sat32(64'(prev_r) + 64'(rnd_v >>> FRACTION_BITS));

  assign div_start = (state_r == S_ISSUE);
  assign div_num   = diffph_nxt ? DEN_W'(DIFF_W'(hi_v) - DIFF_W'(prev_r)) : DEN_W'(dlv);
  assign div_den   = DEN_W'(dlv) + DEN_W'(drv);

  assign tbl_ctl.knot_we = in_acc && (in_kind == KIND_KNOT);
  assign tbl_ctl.coef_we = in_acc && (in_kind == KIND_COEF);

  bsv_tables #(
    .MAX_ORDER (MAX_ORDER),
    .MAX_COEFS (MAX_COEFS),
    .KA_W      (KA_W),
    .CA_W      (CA_W)
  ) u_tables (
    .clk        (clk),
    .ctl        (tbl_ctl),
    .wr_addr    (in_entry_index),
    .wr_data    (in_operand_value),
    .knot_raddr (knot_raddr),
    .coef_raddr (coef_raddr),
    .knot_q     (knot_q),
    .coef_q     (coef_q)
  );

  bsv_divider #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_divider (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r  <= ORD_W'(4);
      n_r  <= CNT_W'(4);
      jd_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ORDER: k_r  <= cfg_data[ORD_W-1:0];
        REG_COUNT: n_r  <= cfg_data[CNT_W-1:0];
        REG_DERIV: jd_r <= cfg_data[ORD_W-1:0];
        default: ;
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      search_start_r <= '0;
      prev_pt_r      <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      search_start_r <= search_start_nxt;
      prev_pt_r      <= prev_pt_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    first_r    <= first_nxt;
    status_r   <= status_nxt;
    res_r      <= res_nxt;
    out_res_r  <= out_res_nxt;
    out_stat_r <= out_stat_nxt;
    m_r        <= m_nxt;
    tmp_r      <= tmp_nxt;
    t0_r       <= t0_nxt;
    tl_r       <= tl_nxt;
    ilo_r      <= ilo_nxt;
    ihi_r      <= ihi_nxt;
    mid_r      <= mid_nxt;
    j_r        <= j_nxt;
    lv_r       <= lv_nxt;
    p_r        <= p_nxt;
    cval_r     <= cval_nxt;
    prev_r     <= prev_nxt;
    cur_r      <= cur_nxt;
    diffab_r   <= diffab_nxt;
    diffph_r   <= diffph_nxt;
    prodd_r    <= prodd_nxt;
    prodr_r    <= prodr_nxt;
    if (aj_we) begin
      aj_r[aj_wa] <= aj_wd;
    end
    if (dl_we) begin
      dl_r[dx_wa] <= dl_wd;
    end
    if (dr_we) begin
      dr_r[dx_wa] <= dr_wd;
    end
  end

  // sequencer
  always_comb begin
    state_nxt        = state_r;
    search_start_nxt = search_start_r;
    prev_pt_nxt      = prev_pt_r;
    out_valid_nxt    = out_valid_r && out_stall;
    x_nxt            = x_r;
    first_nxt        = first_r;
    status_nxt       = status_r;
    res_nxt          = res_r;
    out_res_nxt      = out_res_r;
    out_stat_nxt     = out_stat_r;
    m_nxt            = m_r;
    tmp_nxt          = tmp_r;
    t0_nxt           = t0_r;
    tl_nxt           = tl_r;
    ilo_nxt          = ilo_r;
    ihi_nxt          = ihi_r;
    mid_nxt          = mid_r;
    j_nxt            = j_r;
    lv_nxt           = lv_r;
    p_nxt            = p_r;
    cval_nxt         = cval_r;
    prev_nxt         = prev_r;
    cur_nxt          = cur_r;
    diffab_nxt       = diffab_r;
    diffph_nxt       = diffph_r;
    prodd_nxt        = prodd_r;
    prodr_nxt        = prodr_r;
    aj_we            = 1'b0;
    aj_wa            = p_r;
    aj_wd            = wb_v;
    dl_we            = 1'b0;
    dr_we            = 1'b0;
    dx_wa            = j_r;
    dl_wd            = DIFF_W'(x_r) - DIFF_W'(knot_q);
    dr_wd            = DIFF_W'(knot_q) - DIFF_W'(x_r);
    knot_raddr       = '0;
    coef_raddr       = c_s[CA_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_acc && (in_kind == KIND_EVAL)) begin
          x_nxt      = in_operand_value;
          first_nxt  = in_first_point;
          status_nxt = ST_OK;
          res_nxt    = '0;
          state_nxt  = S_CHK_ORD;
        end
      end

      // order and coefficient count
      S_CHK_ORD: begin
        m_nxt = '0;
        if ((k_r == '0) || (int'(k_r) > MAX_ORDER)) begin
          status_nxt = ST_BAD_ORDER;
          state_nxt  = S_DONE;
        end else if ((n_r < CNT_W'(k_r)) || (int'(n_r) > MAX_COEFS)) begin
          status_nxt = ST_FEW_COEFS;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_MONO_RD;
        end
      end

      // knots must not decrease
      S_MONO_RD: begin
        knot_raddr = m_r[KA_W-1:0];
        state_nxt  = S_MONO_CMP;
      end
      S_MONO_CMP: begin
        tmp_nxt = knot_q;
        if ((m_r != '0) && (tmp_r > knot_q)) begin
          status_nxt = ST_KNOT_DEC;
          state_nxt  = S_DONE;
        end else if (m_r == lxt_m1) begin
          m_nxt     = '0;
          state_nxt = S_MULT_A;
        end else begin
          m_nxt     = m_r + 1'b1;
          state_nxt = S_MONO_RD;
        end
      end

      // every knot span of length k must be nonzero
      S_MULT_A: begin
        knot_raddr = m_r[KA_W-1:0];
        state_nxt  = S_MULT_B;
      end
      S_MULT_B: begin
        tmp_nxt    = knot_q;
        knot_raddr = KA_W'(m_r + POS_W'(k_r));
        state_nxt  = S_MULT_C;
      end
      S_MULT_C: begin
        if (knot_q <= tmp_r) begin
          status_nxt = ST_MULTIPLICITY;
          state_nxt  = S_DONE;
        end else if (m_r == POS_W'(n_r) - 1'b1) begin
          state_nxt = S_CHK_PT;
        end else begin
          m_nxt     = m_r + 1'b1;
          state_nxt = S_MULT_A;
        end
      end

      // grid point must rise unless this is a first point
      S_CHK_PT: begin
        if (!first_r && (x_r <= prev_pt_r)) begin
          status_nxt = ST_X_NOT_INC;
          state_nxt  = S_DONE;
        end else begin
          prev_pt_nxt      = x_r;
          search_start_nxt = ss_eff[KA_W-1:0];
          ilo_nxt          = ss_eff;
          if (jd_r >= k_r) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_LOC_T0;
          end
        end
      end

      // interval search
      S_LOC_T0: begin
        knot_raddr = '0;
        state_nxt  = S_LOC_TL;
      end
      S_LOC_TL: begin
        t0_nxt     = knot_q;
        knot_raddr = lxt_m1[KA_W-1:0];
        state_nxt  = S_LOC_S;
      end
      S_LOC_S: begin
        tl_nxt = knot_q;
        if (ilo_r > lxt_m2) begin
          ilo_nxt   = '0;
          ihi_nxt   = POS_W'(1);
          state_nxt = S_LOC_EXP;
        end else begin
          knot_raddr = ilo_r[KA_W-1:0];
          state_nxt  = S_LOC_SC;
        end
      end
      S_LOC_SC: begin
        if (knot_q > x_r) begin
          ilo_nxt = '0;
          ihi_nxt = POS_W'(1);
        end else begin
          ihi_nxt = ilo_r + 1'b1;
        end
        state_nxt = S_LOC_EXP;
      end
      S_LOC_EXP: begin
        if (ihi_r < lxt_m1) begin
          knot_raddr = ihi_r[KA_W-1:0];
          state_nxt  = S_LOC_EXPC;
        end else begin
          state_nxt = S_LOC_BIN;
        end
      end
      S_LOC_EXPC: begin
        if (x_r >= knot_q) begin
          ihi_nxt   = ihi_exp;
          state_nxt = S_LOC_EXP;
        end else begin
          state_nxt = S_LOC_BIN;
        end
      end
      S_LOC_BIN: begin
        if (ihi_r > ilo_r + 1'b1) begin
          mid_nxt    = POS_W'((ihi_r + ilo_r) >> 1);
          knot_raddr = KA_W'((ihi_r + ilo_r) >> 1);
          state_nxt  = S_LOC_BINC;
        end else begin
          state_nxt = S_LOC_LAST;
        end
      end
      S_LOC_BINC: begin
        if (x_r >= knot_q) begin
          ilo_nxt = mid_r;
        end else begin
          ihi_nxt = mid_r;
        end
        state_nxt = S_LOC_BIN;
      end
      // point on the last knot: step back to the last span of nonzero length
      S_LOC_LAST: begin
        state_nxt = (x_r == tl_r) ? S_LOC_DEC : S_LOC_FLAG;
      end
      S_LOC_DEC: begin
        if (ilo_r != '0) begin
          knot_raddr = ilo_r[KA_W-1:0];
          state_nxt  = S_LOC_DECC;
        end else begin
          state_nxt = S_LOC_FLAG;
        end
      end
      S_LOC_DECC: begin
        if (knot_q >= tl_r) begin
          ilo_nxt   = ilo_r - 1'b1;
          state_nxt = S_LOC_DEC;
        end else begin
          state_nxt = S_LOC_FLAG;
        end
      end
      S_LOC_FLAG: begin
        search_start_nxt = ilo_r[KA_W-1:0];
        j_nxt            = '0;
        if ((x_r < t0_r) || (x_r > tl_r)) begin
          state_nxt = S_DONE;
        end else if (k_r == ORD_W'(1)) begin
          state_nxt = S_AJ_RD;
        end else begin
          state_nxt = S_DL_RD;
        end
      end

      // left and right distances
      S_DL_RD: begin
        knot_raddr = li[KA_W-1:0];
        state_nxt  = S_DL_W;
      end
      S_DL_W: begin
        dl_we      = 1'b1;
        knot_raddr = ri[KA_W-1:0];
        state_nxt  = S_DR_W;
      end
      S_DR_W: begin
        dr_we = 1'b1;
        if (POS_W'(j_r) == POS_W'(k_r) - POS_W'(2)) begin
          j_nxt     = '0;
          state_nxt = S_AJ_RD;
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = S_DL_RD;
        end
      end

      // coefficients around the interval, zero outside the table
      S_AJ_RD: begin
        cval_nxt  = !c_s[POS_W] && (c_s < $signed((POS_W+1)'(n_r)));
        state_nxt = S_AJ_W;
      end
      S_AJ_W: begin
        aj_we = 1'b1;
        aj_wa = j_r;
        aj_wd = cval_r ? coef_q : '0;
        if (POS_W'(j_r) == POS_W'(k_r) - 1'b1) begin
          lv_nxt    = OI_W'(k_r - 1'b1);
          state_nxt = S_OUTER;
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = S_AJ_RD;
        end
      end

      // outer sweep: differencing passes first, then convex combinations
      S_OUTER: begin
        p_nxt    = '0;
        prev_nxt = aj_r[0];
        if (lv_r == '0) begin
          res_nxt   = aj_r[0];
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_ISSUE;
        end
      end
      S_ISSUE: begin
        diffph_nxt = (POS_W'(lv_r) + POS_W'(jd_r)) >= POS_W'(k_r);
        cur_nxt    = hi_v;
        diffab_nxt = DIFF_W'(hi_v) - DIFF_W'(prev_r);
        state_nxt  = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        prodd_nxt = PDW'(div_quo) * PDW'($signed({1'b0, lv_r}));
        prodr_nxt = PRW'(diffab_r) * PRW'(w_v);
        state_nxt = S_WB;
      end
      S_WB: begin
        aj_we    = 1'b1;
        prev_nxt = cur_r;
        if (p_r == lv_r - 1'b1) begin
          lv_nxt    = lv_r - 1'b1;
          state_nxt = S_OUTER;
        end else begin
          p_nxt     = p_inc;
          state_nxt = S_ISSUE;
        end
      end

      // hand over to the output register
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = (status_r == ST_OK) ? res_r : '0;
          out_stat_nxt  = status_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_res_r;
  assign out_status       = out_stat_r;

endmodule
